[hw/rtl/fifo_lock_with_wait_stats_unit_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the FIFO lock unit
// Shared forms of the concurrent checks used in the lock RTL.
// ----------------------------------------------------------------------------
`ifndef FIFO_LOCK_WITH_WAIT_STATS_UNIT_ASSERT_SVH
`define FIFO_LOCK_WITH_WAIT_STATS_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FLWWS_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lock unit check failed");

// The consequent must hold in the cycle after the antecedent.
`define FLWWS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lock unit check failed");

`endif

[hw/rtl/flwws_pkg.sv]
// ----------------------------------------------------------------------------
// FIFO lock package
// Types, widths and helpers shared by the lock unit and its cells.
// ----------------------------------------------------------------------------
package flwws_pkg;

   localparam int ID_W           = 4;
   localparam int TIME_W         = 32;
   localparam int TOTAL_W        = 48;
   localparam int SAMPLES_W      = 32;
   localparam int QCNT_W         = 5;
   localparam int MAX_IDS        = 1 << ID_W;
   localparam int AGENTS_DEFAULT = 16;

   typedef enum logic [1:0] {
      OP_REQUEST = 2'd0,
      OP_RELEASE = 2'd1,
      OP_QUERY   = 2'd2,
      OP_RESET   = 2'd3
   } op_type;

   // Command broadcast to every queue cell for one transaction.
   typedef struct packed {
      logic              step;
      logic              clear;
      logic              remove;
      logic              append;
      logic [ID_W-1:0]   id;
      logic [TIME_W-1:0] now;
   } cell_ctrl_type;

   // Contents of one queue cell as seen by its neighbor.
   typedef struct packed {
      logic              occupied;
      logic [ID_W-1:0]   id;
      logic [TIME_W-1:0] arrival;
   } cell_link_type;

   // Command to the statistics accumulator.
   typedef struct packed {
      logic              clear;
      logic              account;
      logic [TIME_W-1:0] wait_ticks;
   } stats_ctrl_type;

   // Wait since arrival; time running backwards counts as no wait.
   function automatic logic [TIME_W-1:0] clamped_wait(input logic [TIME_W-1:0] now,
                                                      input logic [TIME_W-1:0] start);
      return (now >= start) ? (now - start) : '0;
   endfunction

endpackage

[hw/rtl/flwws_cell.sv]
// ----------------------------------------------------------------------------
// FIFO lock queue cell
// One wait-queue slot: agent id and arrival time, shifting toward the head.
// ----------------------------------------------------------------------------
module flwws_cell import flwws_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  cell_ctrl_type       ctrl,
   input  logic                left_occupied,
   input  cell_link_type       right_link,
   input  logic                kill_in,
   input  logic [TIME_W-1:0]   sel_in,
   output cell_link_type       link,
   output logic                kill_out,
   output logic [TIME_W-1:0]   sel_out
);

   logic              occupied_ff, occupied_in;
   logic [ID_W-1:0]   id_ff, id_in;
   logic [TIME_W-1:0] arrival_ff, arrival_in;
   logic              match;

   assign match    = occupied_ff && (id_ff == ctrl.id);
   // Once the removed entry is found, every cell from there on pulls from the right.
   assign kill_out = kill_in | match;
   assign sel_out  = sel_in | (match ? arrival_ff : '0);

   assign link.occupied = occupied_ff;
   assign link.id       = id_ff;
   assign link.arrival  = arrival_ff;

   always_comb begin
      occupied_in = occupied_ff;
      id_in       = id_ff;
      arrival_in  = arrival_ff;
      if (ctrl.step) begin
         priority if (ctrl.clear) begin
            occupied_in = 1'b0;
         end else if (ctrl.remove && kill_out) begin
            occupied_in = right_link.occupied;
            id_in       = right_link.id;
            arrival_in  = right_link.arrival;
         end else if (ctrl.append && !occupied_ff && left_occupied) begin
            occupied_in = 1'b1;
            id_in       = ctrl.id;
            arrival_in  = ctrl.now;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occupied_ff <= 1'b0;
      end else begin
         occupied_ff <= occupied_in;
      end
   end

   always_ff @(posedge clock) begin
      id_ff      <= id_in;
      arrival_ff <= arrival_in;
   end

endmodule

[hw/rtl/flwws_stats.sv]
// ----------------------------------------------------------------------------
// FIFO lock wait statistics
// Saturating total of accounted wait ticks and saturating sample count.
// ----------------------------------------------------------------------------
module flwws_stats import flwws_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  stats_ctrl_type       ctrl,
   output logic [TOTAL_W-1:0]   wait_total,
   output logic [SAMPLES_W-1:0] wait_samples
);

   logic [TOTAL_W-1:0]   total_ff, total_in;
   logic [SAMPLES_W-1:0] samples_ff, samples_in;
   logic [TOTAL_W:0]     sum;

   assign sum = {1'b0, total_ff} + (TOTAL_W + 1)'(ctrl.wait_ticks);

   always_comb begin
      total_in   = total_ff;
      samples_in = samples_ff;
      priority if (ctrl.clear) begin
         total_in   = '0;
         samples_in = '0;
      end else if (ctrl.account) begin
         total_in   = sum[TOTAL_W] ? '1 : sum[TOTAL_W-1:0];
         samples_in = (samples_ff == '1) ? samples_ff : samples_ff + SAMPLES_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff   <= '0;
         samples_ff <= '0;
      end else begin
         total_ff   <= total_in;
         samples_ff <= samples_in;
      end
   end

   assign wait_total   = total_ff;
   assign wait_samples = samples_ff;

endmodule

[hw/rtl/fifo_lock_with_wait_stats_unit.sv]
// ----------------------------------------------------------------------------
// FIFO lock with wait statistics
// Single-owner lock with a first-in first-out wait queue built as a row of
// cells, plus saturating wait-time statistics.
// ----------------------------------------------------------------------------
//
//   channel | direction | tdata                                  | tuser
//   --------+-----------+----------------------------------------+-----------------
//   req_    | in        | agent_id, timestamp                    | op, agent_valid
//   rsp_    | out       | granted .. wait_samples (see port)     | none
//
// One transaction is handled per clock cycle unless stalled; the result is
// registered and appears in the cycle after acceptance. The single result
// register sets the rate: while a result waits on rsp_tready, no new request
// transaction is taken, and one is taken in the cycle the result leaves.
// Reset is synchronous and active high; it empties the queue, frees the lock
// and zeroes the statistics at once, with no clearing pass.
// The queue lives in a row of cells, head at cell zero. A lookup compares the
// agent id in every cell in parallel; a removal anywhere shifts all later
// cells one place toward the head in the same cycle, and an append fills the
// first empty cell.
// ----------------------------------------------------------------------------
module fifo_lock_with_wait_stats_unit import flwws_pkg::*; #(
   parameter int AGENTS = AGENTS_DEFAULT
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // [3:0] agent_id, [35:4] timestamp, [39:36] zero
   input  logic [39:0]  req_tdata,
   // [1:0] op, [2] agent_valid
   input  logic [2:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // [0] granted, [1] lock_held, [5:2] holder_id, [10:6] queue_count,
   // [42:11] wait_duration, [90:43] wait_total, [122:91] wait_samples,
   // [127:123] zero
   output logic [127:0] rsp_tdata
);

`include "fifo_lock_with_wait_stats_unit_assert.svh"

   // Only ids that fit the id field can ever be queued, so the queue never
   // needs more cells than that.
   localparam int Depth  = (AGENTS < MAX_IDS) ? AGENTS : MAX_IDS;
   localparam int CountW = $clog2(Depth + 1);

   // Request fields.
   op_type            req_op;
   logic [ID_W-1:0]   req_agent_id;
   logic              req_agent_valid;
   logic [TIME_W-1:0] req_timestamp;

   assign req_op          = op_type'(req_tuser[1:0]);
   assign req_agent_valid = req_tuser[2];
   assign req_agent_id    = req_tdata[3:0];
   assign req_timestamp   = req_tdata[35:4];

   logic accept;
   assign req_tready = !rsp_tvalid || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   // Lock state.
   logic              holder_present_ff, holder_present_in;
   logic [ID_W-1:0]   holder_ff, holder_in;
   logic [CountW-1:0] qlen_ff, qlen_in;

   // Result register. The state registers only move on acceptance, which
   // coincides with loading a new result, so they can drive the rest of the
   // result directly.
   logic              rsp_valid_ff, rsp_valid_in;
   logic              granted_ff, granted_in;
   logic [TIME_W-1:0] wait_ff, wait_in;

   // Cell row wiring.
   cell_ctrl_type     cell_ctrl;
   cell_link_type     link [Depth+1];
   logic              kill [Depth+1];
   logic [TIME_W-1:0] sel  [Depth+1];
   logic [Depth-1:0]  occupied_vec;
   logic [Depth-1:0]  holder_queued_vec;

   assign link[Depth] = '0;
   assign kill[0]     = 1'b0;
   assign sel[0]      = '0;

   for (genvar i = 0; i < Depth; i++) begin : g_cell
      logic left_occupied;
      if (i == 0) begin : g_head
         assign left_occupied = 1'b1;
      end else begin : g_body
         assign left_occupied = link[i-1].occupied;
      end

      flwws_cell u_cell (
         .clock         (clock),
         .reset         (reset),
         .ctrl          (cell_ctrl),
         .left_occupied (left_occupied),
         .right_link    (link[i+1]),
         .kill_in       (kill[i]),
         .sel_in        (sel[i]),
         .link          (link[i]),
         .kill_out      (kill[i+1]),
         .sel_out       (sel[i+1])
      );

      assign occupied_vec[i]      = link[i].occupied;
      assign holder_queued_vec[i] = link[i].occupied && (link[i].id == holder_ff);
   end

   // Lookup results: hit means the agent is queued, sel holds its arrival.
   logic              hit;
   logic              head_match;
   logic              agent_ok;
   logic              is_holder;
   logic [TIME_W-1:0] matched_wait;

   assign hit          = kill[Depth];
   assign head_match   = link[0].occupied && (link[0].id == req_agent_id);
   assign agent_ok     = req_agent_valid && (32'(req_agent_id) < 32'(AGENTS));
   assign is_holder    = holder_present_ff && (holder_ff == req_agent_id);
   assign matched_wait = clamped_wait(req_timestamp, sel[Depth]);

   stats_ctrl_type       stats_ctrl;
   logic [TOTAL_W-1:0]   stats_total;
   logic [SAMPLES_W-1:0] stats_samples;

   flwws_stats u_stats (
      .clock        (clock),
      .reset        (reset),
      .ctrl         (stats_ctrl),
      .wait_total   (stats_total),
      .wait_samples (stats_samples)
   );

   // Transaction decode.
   logic do_clear, do_remove, do_append, do_account, do_grant;
   logic [TIME_W-1:0] account_wait;

   always_comb begin
      do_clear     = 1'b0;
      do_remove    = 1'b0;
      do_append    = 1'b0;
      do_account   = 1'b0;
      do_grant     = 1'b0;
      account_wait = '0;
      holder_in         = holder_ff;
      holder_present_in = holder_present_ff;
      wait_in           = '0;

      unique case (req_op)
         OP_REQUEST: begin
            if (agent_ok && !is_holder) begin
               if (hit) begin
                  // Already waiting: granted only from the head of the queue.
                  if (!holder_present_ff && head_match) begin
                     do_grant     = 1'b1;
                     do_remove    = 1'b1;
                     do_account   = 1'b1;
                     account_wait = matched_wait;
                  end
               end else if (!holder_present_ff && (qlen_ff == '0)) begin
                  // New arrival at a free lock with nobody waiting: it enters
                  // and leaves the queue at once with a zero wait.
                  do_grant   = 1'b1;
                  do_account = 1'b1;
               end else begin
                  do_append = (32'(qlen_ff) < 32'(Depth));
               end
            end
            if (do_grant) begin
               holder_in         = req_agent_id;
               holder_present_in = 1'b1;
            end
         end
         OP_RELEASE: begin
            if (agent_ok) begin
               if (is_holder) begin
                  holder_in         = '0;
                  holder_present_in = 1'b0;
               end
               if (hit) begin
                  // A waiter that gives up still has its wait counted.
                  do_remove    = 1'b1;
                  do_account   = 1'b1;
                  account_wait = matched_wait;
               end
            end
         end
         OP_QUERY: begin
            if (agent_ok && hit) begin
               wait_in = matched_wait;
            end
         end
         OP_RESET: begin
            do_clear          = 1'b1;
            holder_in         = '0;
            holder_present_in = 1'b0;
         end
         default: begin
            do_clear = 1'b0;
         end
      endcase

      granted_in = agent_ok && (req_op == OP_REQUEST) && (is_holder || do_grant);
   end

   always_comb begin
      cell_ctrl.step   = accept;
      cell_ctrl.clear  = do_clear;
      cell_ctrl.remove = do_remove;
      cell_ctrl.append = do_append;
      cell_ctrl.id     = req_agent_id;
      cell_ctrl.now    = req_timestamp;

      stats_ctrl.clear      = accept && do_clear;
      stats_ctrl.account    = accept && do_account;
      stats_ctrl.wait_ticks = account_wait;
   end

   always_comb begin
      priority if (do_clear) begin
         qlen_in = '0;
      end else if (do_remove) begin
         qlen_in = qlen_ff - CountW'(1);
      end else if (do_append) begin
         qlen_in = qlen_ff + CountW'(1);
      end else begin
         qlen_in = qlen_ff;
      end
   end

   always_comb begin
      priority if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         holder_present_ff <= 1'b0;
         holder_ff         <= '0;
         qlen_ff           <= '0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            holder_present_ff <= holder_present_in;
            holder_ff         <= holder_in;
            qlen_ff           <= qlen_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         granted_ff <= granted_in;
         wait_ff    <= wait_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      rsp_tdata          = '0;
      rsp_tdata[0]       = granted_ff;
      rsp_tdata[1]       = holder_present_ff;
      rsp_tdata[5:2]     = holder_present_ff ? holder_ff : '0;
      rsp_tdata[10:6]    = QCNT_W'(qlen_ff);
      rsp_tdata[42:11]   = wait_ff;
      rsp_tdata[90:43]   = stats_total;
      rsp_tdata[122:91]  = stats_samples;
   end

   // The length counter and the occupied cells must always agree.
   `FLWWS_ASSERT_SAME(a_qlen_matches_cells, clock, reset, 1'b1,
                      32'(qlen_ff) == 32'($countones(occupied_vec)))
   // The agent holding the lock is never also waiting for it.
   `FLWWS_ASSERT_SAME(a_holder_not_queued, clock, reset, holder_present_ff,
                      holder_queued_vec == '0)
   // A granted result always shows the lock as held.
   `FLWWS_ASSERT_SAME(a_grant_holds_lock, clock, reset, rsp_valid_ff && granted_ff,
                      holder_present_ff)
   // The sample count only drops on a reset transaction.
   `FLWWS_ASSERT_NEXT(a_samples_monotonic, clock, reset, accept && (req_op != OP_RESET),
                      stats_samples >= $past(stats_samples))

endmodule
